// ----- rtl/afs_pkg.sv -----
// Shared types and constants for the ADC frame serializer.
// No dependencies; imported by every module of the block.
`default_nettype none

package afs_pkg;

    localparam int CHANNELS     = 4;
    localparam int INPUT_FIELDS = 4;
    localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int DIGITS      = 6;
    localparam int FRAC_DIGITS = DIGITS - 1;
    localparam int PIPE_STAGES = 2 + FRAC_DIGITS;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 14;
    localparam int Y_W      = 19;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_PERIOD = 2'd1;

    localparam logic MODE_RAW   = 1'b0;
    localparam logic MODE_ASCII = 1'b1;

    localparam logic [7:0] SYNC_PERIOD_RESET = 8'd4;

    localparam logic [7:0] SYNC_BYTE  = 8'h80;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam logic signed [SAMPLE_W-1:0] RAW_MAX = 16'sd127;
    localparam logic signed [SAMPLE_W-1:0] RAW_MIN = -16'sd127;

    localparam logic [MAG_W:0] SCALE_NUM   = 15'd10625;
    localparam int             SCALE_SHIFT = 8;

    typedef struct packed {
        logic mode;
        logic sync;
    } frame_ctl_t;

    typedef struct packed {
        logic [7:0]             raw;
        logic                   neg;
        logic [DIGITS-1:0][3:0] digit;
    } chan_result_t;

endpackage

`default_nettype wire

// ----- rtl/afs_lane.sv -----
// One channel lane: raw clamp and fixed-point voltage with decimal digits.
// Depends on afs_pkg; PIPE_STAGES register stages, all advanced by en.
`default_nettype none

module afs_lane (
    input  wire                                  aclk,
    input  wire                                  en,
    input  wire logic signed [afs_pkg::SAMPLE_W-1:0] sample,
    output afs_pkg::chan_result_t                result
);
    import afs_pkg::*;

    function automatic logic [Y_W+3:0] div10(input logic [Y_W-1:0] v);
        logic [Y_W+15-1:0] prod;
        logic [Y_W-1:0]    q;
        logic [Y_W-1:0]    r;
        begin
            prod = v * 15'd26214;
            q    = Y_W'(prod[Y_W+15-1:18]);
            r    = v - ((q << 3) + (q << 1));
            if (r >= Y_W'(10)) begin
                q = q + Y_W'(1);
                r = r - Y_W'(10);
            end
            div10 = {q, r[3:0]};
        end
    endfunction

    logic [7:0]       raw_a_reg;
    logic             neg_a_reg;
    logic [MAG_W-1:0] mag_a_reg;

    logic [Y_W-1:0]         val_reg [FRAC_DIGITS+1];
    logic [DIGITS-1:0][3:0] dig_reg [FRAC_DIGITS+1];
    logic [7:0]             raw_reg [FRAC_DIGITS+1];
    logic                   sgn_reg [FRAC_DIGITS+1];

    logic [7:0]             raw_next;
    logic [MAG_W-1:0]       low_bits;
    logic [2*MAG_W:0]       prod_b;
    logic [Y_W-1:0]         y_b;

    always_comb begin
        if (sample > RAW_MAX) begin
            raw_next = RAW_MAX[7:0];
        end else if (sample < RAW_MIN) begin
            raw_next = RAW_MIN[7:0];
        end else begin
            raw_next = sample[7:0];
        end
        low_bits = sample[MAG_W-1:0];
        prod_b   = mag_a_reg * SCALE_NUM;
        y_b      = prod_b[Y_W+SCALE_SHIFT-1:SCALE_SHIFT];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            raw_a_reg <= raw_next;
            neg_a_reg <= low_bits[MAG_W-1];
            mag_a_reg <= low_bits[MAG_W-1] ? (~low_bits + MAG_W'(1)) : low_bits;
            val_reg[0] <= y_b;
            dig_reg[0] <= '0;
            raw_reg[0] <= raw_a_reg;
            sgn_reg[0] <= neg_a_reg && (y_b != '0);
        end
    end

    for (genvar k = 1; k <= FRAC_DIGITS; k++) begin : g_div
        logic [Y_W+3:0]         dv;
        logic [DIGITS-1:0][3:0] dig_next;
        assign dv = div10(val_reg[k-1]);
        always_comb begin
            dig_next      = dig_reg[k-1];
            dig_next[k-1] = dv[3:0];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                val_reg[k]        <= dv[Y_W+3:4];
                dig_reg[k]        <= dig_next;
                raw_reg[k]        <= raw_reg[k-1];
                sgn_reg[k]        <= sgn_reg[k-1];
            end
        end
    end

    always_comb begin
        result.raw                 = raw_reg[FRAC_DIGITS];
        result.neg                 = sgn_reg[FRAC_DIGITS];
        result.digit               = dig_reg[FRAC_DIGITS];
        result.digit[DIGITS-1]     = val_reg[FRAC_DIGITS][3:0];
    end

endmodule

`default_nettype wire

// ----- rtl/afs_serializer.sv -----
// Merge stage: holds one finished frame from all lanes and sends it byte by byte.
// Depends on afs_pkg; fed by the lane pipeline in the top level.
`default_nettype none

module afs_serializer (
    input  wire                                        aclk,
    input  wire                                        aresetn,
    input  wire                                        in_valid,
    output logic                                       in_ready,
    input  wire afs_pkg::frame_ctl_t                   in_ctl,
    input  wire afs_pkg::chan_result_t [afs_pkg::CHANNELS-1:0] in_chan,
    output logic                                       m_valid,
    input  wire                                        m_ready,
    output logic [7:0]                                 m_out_byte,
    output logic                                       m_last_byte
);
    import afs_pkg::*;

    localparam logic [3:0] POS_SIGN  = 4'd0;
    localparam logic [3:0] POS_INT   = 4'd1;
    localparam logic [3:0] POS_DOT   = 4'd2;
    localparam logic [3:0] POS_FRAC0 = 4'd3;
    localparam logic [3:0] POS_FRAC1 = 4'd4;
    localparam logic [3:0] POS_FRAC2 = 4'd5;
    localparam logic [3:0] POS_FRAC3 = 4'd6;
    localparam logic [3:0] POS_FRAC4 = 4'd7;
    localparam logic [3:0] POS_END   = 4'd8;

    chan_result_t [CHANNELS-1:0] frame_reg;
    logic                        frame_valid_reg;
    logic                        mode_reg;
    logic                        sync_pend_reg;
    logic [CH_W-1:0]             ch_reg;
    logic [3:0]                  pos_reg;

    chan_result_t cur;
    logic         ch_last;
    logic         take;
    logic         load;

    always_comb begin
        cur     = frame_reg[ch_reg];
        ch_last = (ch_reg == CH_W'(CHANNELS - 1));
        if (mode_reg == MODE_RAW) begin
            m_out_byte  = sync_pend_reg ? SYNC_BYTE : cur.raw;
            m_last_byte = !sync_pend_reg && ch_last;
        end else begin
            m_last_byte = ch_last && (pos_reg == POS_END);
            case (pos_reg)
                POS_SIGN:  m_out_byte = cur.neg ? CHAR_MINUS : CHAR_SPACE;
                POS_INT:   m_out_byte = CHAR_ZERO + {4'd0, cur.digit[5]};
                POS_DOT:   m_out_byte = CHAR_DOT;
                POS_FRAC0: m_out_byte = CHAR_ZERO + {4'd0, cur.digit[4]};
                POS_FRAC1: m_out_byte = CHAR_ZERO + {4'd0, cur.digit[3]};
                POS_FRAC2: m_out_byte = CHAR_ZERO + {4'd0, cur.digit[2]};
                POS_FRAC3: m_out_byte = CHAR_ZERO + {4'd0, cur.digit[1]};
                POS_FRAC4: m_out_byte = CHAR_ZERO + {4'd0, cur.digit[0]};
                POS_END:   m_out_byte = ch_last ? CHAR_CR : CHAR_SEMI;
                default:   m_out_byte = CHAR_SPACE;
            endcase
        end
        m_valid  = frame_valid_reg;
        take     = frame_valid_reg && m_ready;
        in_ready = !frame_valid_reg || (take && m_last_byte);
        load     = in_valid && in_ready;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            frame_reg <= in_chan;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_valid_reg <= 1'b0;
            mode_reg        <= MODE_RAW;
            sync_pend_reg   <= 1'b0;
            ch_reg          <= '0;
            pos_reg         <= POS_SIGN;
        end else if (load) begin
            frame_valid_reg <= 1'b1;
            mode_reg        <= in_ctl.mode;
            sync_pend_reg   <= in_ctl.sync && (in_ctl.mode == MODE_RAW);
            ch_reg          <= '0;
            pos_reg         <= POS_SIGN;
        end else if (take) begin
            if (m_last_byte) begin
                frame_valid_reg <= 1'b0;
            end else if (mode_reg == MODE_RAW) begin
                if (sync_pend_reg) begin
                    sync_pend_reg <= 1'b0;
                end else begin
                    ch_reg <= ch_reg + CH_W'(1);
                end
            end else if (pos_reg == POS_END) begin
                pos_reg <= POS_SIGN;
                ch_reg  <= ch_reg + CH_W'(1);
            end else begin
                pos_reg <= pos_reg + 4'd1;
            end
        end
    end

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_END)
        else $error("character position out of range");

    a_ch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ch_reg <= CH_W'(CHANNELS - 1))
        else $error("channel index out of range");

    a_raw_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_RAW) |-> (pos_reg == POS_SIGN))
        else $error("character position moved in raw mode");

    a_sync_first: assert property (@(posedge aclk) disable iff (!aresetn)
        sync_pend_reg |-> (mode_reg == MODE_RAW && ch_reg == '0))
        else $error("sync byte pending past the first channel");

endmodule

`default_nettype wire

// ----- rtl/adc_frame_serializer_core.sv -----
// Top level of the ADC frame serializer: config registers, frame counter,
// lane pipeline control. Depends on afs_pkg, afs_lane and afs_serializer.
//
//   channel | direction | handshake        | payload
//   s_      | in        | s_valid/s_ready  | s_sample_0..s_sample_3 (16 b signed)
//   m_      | out       | m_valid/m_ready  | m_out_byte (8 b), m_last_byte
//   cfg_    | in        | cfg_write        | cfg_index (2 b), cfg_wdata (8 b)
//
// A frame passes through the PIPE_STAGES lane stages: clamp/magnitude, scale
// multiply, then one divide-by-ten per stage. The serializer sends one byte a
// cycle while m_ready is high, so a frame occupies it for 36 bytes in ASCII
// mode, CHANNELS or CHANNELS+1 bytes in raw mode; that sets the sustained rate.
// While the serializer is busy, frames enter until one reaches the last stage.
// Reset is synchronous and active low; no clearing pass.
`default_nettype none

module adc_frame_serializer_core (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire                                     cfg_write,
    input  wire logic [afs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [afs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire                                     s_valid,
    output logic                                    s_ready,
    input  wire logic signed [afs_pkg::SAMPLE_W-1:0] s_sample_0,
    input  wire logic signed [afs_pkg::SAMPLE_W-1:0] s_sample_1,
    input  wire logic signed [afs_pkg::SAMPLE_W-1:0] s_sample_2,
    input  wire logic signed [afs_pkg::SAMPLE_W-1:0] s_sample_3,
    output logic                                    m_valid,
    input  wire                                     m_ready,
    output logic [7:0]                              m_out_byte,
    output logic                                    m_last_byte
);
    import afs_pkg::*;

    logic       output_mode_reg;
    logic [7:0] sync_period_reg;
    logic [7:0] frame_count_reg;
    logic [7:0] frame_count_next;

    logic [PIPE_STAGES-1:0] valid_reg;
    frame_ctl_t             ctl_reg [PIPE_STAGES];

    logic                          pipe_en;
    logic                          accept;
    logic                          ser_ready;
    logic                          sync_hit;
    frame_ctl_t                    ctl_in;
    logic signed [SAMPLE_W-1:0]    lane_in [CHANNELS];
    chan_result_t [CHANNELS-1:0]   lane_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_mode_reg <= MODE_RAW;
            sync_period_reg <= SYNC_PERIOD_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_OUTPUT_MODE: output_mode_reg <= cfg_wdata[0];
                REG_SYNC_PERIOD: sync_period_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        pipe_en          = !valid_reg[PIPE_STAGES-1] || ser_ready;
        s_ready          = pipe_en;
        accept           = s_valid && pipe_en;
        frame_count_next = frame_count_reg + 8'd1;
        sync_hit         = (output_mode_reg == MODE_RAW) &&
                           (frame_count_next == sync_period_reg);
        ctl_in.mode      = output_mode_reg;
        ctl_in.sync      = sync_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= '0;
        end else if (accept && output_mode_reg == MODE_RAW) begin
            frame_count_reg <= sync_hit ? 8'd0 : frame_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[PIPE_STAGES-2:0], accept};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ctl_reg[0] <= ctl_in;
            for (int k = 1; k < PIPE_STAGES; k++) begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        if (g == 0) begin : g_in
            assign lane_in[g] = s_sample_0;
        end else if (g == 1) begin : g_in
            assign lane_in[g] = s_sample_1;
        end else if (g == 2) begin : g_in
            assign lane_in[g] = s_sample_2;
        end else if (g == 3) begin : g_in
            assign lane_in[g] = s_sample_3;
        end else begin : g_in
            assign lane_in[g] = '0;
        end

        afs_lane u_lane (
            .aclk   (aclk),
            .en     (pipe_en),
            .sample (lane_in[g]),
            .result (lane_out[g])
        );
    end

    afs_serializer u_ser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (valid_reg[PIPE_STAGES-1]),
        .in_ready    (ser_ready),
        .in_ctl      (ctl_reg[PIPE_STAGES-1]),
        .in_chan     (lane_out),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte)
    );

endmodule

`default_nettype wire
